// ===== design/gap_pkg.sv =====
// Shared types, constants and helpers for the greedy atlas packer.
// Used by gap_sqrt, gap_ctrl, gap_dpath and the top level; no dependencies.
`timescale 1ns / 1ps
package gap_pkg;

  localparam int unsigned GAP_MAX_RECTS = 64;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned DEPTH         = 2 ** IDX_W;
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned AREA_W        = 22;
  localparam int unsigned ROOT_W        = 12;
  localparam logic [12:0] WIDTH_CAP     = 13'd2048;

  // result register update selected by the controller
  typedef enum logic [1:0] {
    RES_HOLD,
    RES_FIRST,
    RES_NONE,
    RES_FIT
  } res_op_e;

  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] load_addr;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic             key_load;
    logic             rank_acc;
    logic             sort_we;
    logic             sum_clr;
    logic             sqrt_start;
    logic             width_mul;
    logic             width_set;
    logic             cur_load;
    logic             cand_load;
    logic             side;
    res_op_e          res_op;
    logic             place_we;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic fit;
  } stat_t;

  // smallest power of two at or above v (1 for v = 0)
  function automatic logic [15:0] pow2_ceil(input logic [15:0] v);
    logic [15:0] p;
    p = 16'h8000;
    for (int k = 15; k >= 0; k--) begin
      if ((17'd1 << k) >= {1'b0, v}) begin
        p = 16'(17'd1 << k);
      end
    end
    return p;
  endfunction

endpackage

// ===== design/gap_sqrt.sv =====
// Iterative integer square root, one result bit from two radicand bits per step.
// Depends on gap_pkg for widths.
`timescale 1ns / 1ps
module gap_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gap_pkg::AREA_W-1:0]  a_i,
  output logic                        done_o,
  output logic [gap_pkg::ROOT_W-1:0]  root_o
);
  import gap_pkg::*;

  logic [AREA_W-1:0] a_q, r_q, bit_q;
  logic              busy_q;
  logic [AREA_W:0]   trial;

  assign trial  = {1'b0, r_q} + {1'b0, bit_q};
  assign done_o = ~busy_q;
  assign root_o = r_q[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      r_q   <= '0;
      bit_q <= AREA_W'(1) << (AREA_W - 2);
    end else if (busy_q) begin
      if ({1'b0, a_q} >= trial) begin
        a_q <= AREA_W'({1'b0, a_q} - trial);
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== design/gap_dpath.sv =====
// Packer datapath: load/sort/position memories, rank and area accumulation,
// atlas width, parallel overlap cells and the output register. Uses gap_pkg, gap_sqrt.
`timescale 1ns / 1ps
module gap_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gap_pkg::cmd_t  cmd_i,
  output gap_pkg::stat_t stat_o,
  input  logic [7:0]     rect_w_i,
  input  logic [7:0]     rect_h_i,
  output logic [63:0]    m_tdata_o,
  output logic           m_tuser_o,
  output logic           m_tlast_o
);
  import gap_pkg::*;

  // memories
  logic [15:0] load_mem [DEPTH];   // {h, w} in load order
  logic [21:0] sort_mem [DEPTH];   // {order, h, w} in sorted order
  logic [25:0] pos_mem  [DEPTH];   // {ok, y, x} in sorted order
  logic [15:0] ld_a_q, ld_b_q;
  logic [21:0] so_a_q, so_b_q;
  logic [25:0] pos_b_q;

  // sort and width
  logic [15:0]       key_q;
  logic [IDX_W-1:0]  rank_q;
  logic [AREA_W-1:0] area_q;
  logic [8:0]        widest_q;
  logic [23:0]       sq_q;
  logic [11:0]       aw_q;
  logic [15:0]       ah_q;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;

  // placement
  logic [7:0]  cur_w_q, cur_h_q;
  logic [12:0] cand_bx_q;
  logic [15:0] cand_by_q;
  logic        cand_ok_q;
  logic [10:0] res_x_q;
  logic [13:0] res_y_q;
  logic        res_ok_q;

  // overlap cells, one per placed rectangle
  logic [10:0]      cx_q [DEPTH];
  logic [13:0]      cy_q [DEPTH];
  logic [12:0]      cr_q [DEPTH];
  logic [15:0]      cb_q [DEPTH];
  logic [DEPTH-1:0] cv_q;

  gap_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .a_i     (area_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      load_mem[cmd_i.load_addr] <= {rect_h_i, rect_w_i};
    end
    ld_a_q <= load_mem[cmd_i.addr_a];
    ld_b_q <= load_mem[cmd_i.addr_b];
    if (cmd_i.sort_we) begin
      sort_mem[rank_q] <= {cmd_i.addr_a, key_q};
    end
    so_a_q <= sort_mem[cmd_i.addr_a];
    so_b_q <= sort_mem[cmd_i.addr_b];
    if (cmd_i.place_we) begin
      pos_mem[cmd_i.addr_a] <= {res_ok_q, res_y_q, res_x_q};
    end
    pos_b_q <= pos_mem[cmd_i.addr_b];
  end

  // stable rank: count keys that sort ahead of key i
  logic ahead;
  assign ahead = (ld_b_q > key_q) || ((ld_b_q == key_q) && (cmd_i.addr_b < cmd_i.addr_a));

  logic [12:0] r_round, w_max, w_cap;
  assign r_round = {1'b0, root} + {12'd0, ({2'b0, area_q} > sq_q)};
  assign w_max   = (r_round > {4'd0, widest_q}) ? r_round : {4'd0, widest_q};
  assign w_cap   = (w_max > WIDTH_CAP) ? WIDTH_CAP : w_max;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      area_q   <= '0;
      widest_q <= '0;
    end else if (cmd_i.key_load) begin
      key_q    <= ld_a_q;
      rank_q   <= '0;
      area_q   <= area_q + AREA_W'({8'd0, ld_a_q[15:8]} * {8'd0, ld_a_q[7:0]});
      if ({1'b0, ld_a_q[7:0]} + 9'd2 > widest_q) begin
        widest_q <= {1'b0, ld_a_q[7:0]} + 9'd2;
      end
    end else if (cmd_i.rank_acc && ahead) begin
      rank_q <= rank_q + IDX_W'(1);
    end
    if (cmd_i.width_mul) begin
      sq_q <= ({12'd0, root} * {12'd0, root}) + {12'd0, root};
    end
    if (cmd_i.width_set) begin
      aw_q <= 12'(pow2_ceil({3'd0, w_cap}));
    end
  end

  // candidate box from the anchor rectangle
  logic [7:0]  anc_w, anc_h;
  logic [10:0] anc_x;
  logic [13:0] anc_y;
  assign anc_w = so_b_q[7:0];
  assign anc_h = so_b_q[15:8];
  assign anc_x = pos_b_q[10:0];
  assign anc_y = pos_b_q[24:11];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_load) begin
      cur_w_q <= so_a_q[7:0];
      cur_h_q <= so_a_q[15:8];
    end
    if (cmd_i.cand_load) begin
      cand_ok_q <= pos_b_q[25];
      if (cmd_i.side) begin
        cand_bx_q <= {2'd0, anc_x};
        cand_by_q <= {2'd0, anc_y} + {8'd0, anc_h} + 16'd1;
      end else begin
        cand_bx_q <= {2'd0, anc_x} + {5'd0, anc_w} + 13'd1;
        cand_by_q <= {2'd0, anc_y};
      end
    end
  end

  // fit test against every placed cell at once
  logic [8:0]       bw, bh;
  logic [12:0]      bxl, bxr;
  logic [15:0]      byt, byb;
  logic             in_width;
  logic [DEPTH-1:0] hit;
  assign bw       = {1'b0, cur_w_q} + 9'd2;
  assign bh       = {1'b0, cur_h_q} + 9'd2;
  assign bxl      = cand_bx_q + 13'd1;
  assign bxr      = cand_bx_q + 13'd1 + {4'd0, bw};
  assign byt      = cand_by_q + 16'd1;
  assign byb      = cand_by_q + 16'd1 + {7'd0, bh};
  assign in_width = (cand_bx_q + {4'd0, bw}) <= {1'b0, aw_q};

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      hit[k] = cv_q[k] && !((bxr <= {2'd0, cx_q[k]}) || (byb <= {2'd0, cy_q[k]}) ||
                            (bxl >= cr_q[k]) || (byt >= cb_q[k]));
    end
  end

  assign stat_o.fit       = cand_ok_q && in_width && !(|hit);
  assign stat_o.sqrt_done = sqrt_done;

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      RES_FIRST: begin
        res_x_q  <= 11'd1;
        res_y_q  <= 14'd1;
        res_ok_q <= 1'b1;
      end
      RES_NONE: begin
        res_x_q  <= '0;
        res_y_q  <= '0;
        res_ok_q <= 1'b0;
      end
      RES_FIT: begin
        res_x_q  <= cmd_i.side ? cand_bx_q[10:0] : 11'(cand_bx_q + 13'd1);
        res_y_q  <= cmd_i.side ? 14'(cand_by_q + 16'd1) : cand_by_q[13:0];
        res_ok_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic [15:0] hp;
  assign hp = pow2_ceil({2'd0, res_y_q} + {8'd0, cur_h_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (cmd_i.width_set) begin
      cv_q <= '0;
    end else if (cmd_i.place_we && res_ok_q) begin
      cv_q[cmd_i.addr_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.width_set) begin
      ah_q <= '0;
    end else if (cmd_i.place_we && res_ok_q) begin
      cx_q[cmd_i.addr_a] <= res_x_q;
      cy_q[cmd_i.addr_a] <= res_y_q;
      cr_q[cmd_i.addr_a] <= {2'd0, res_x_q} + {5'd0, cur_w_q} + 13'd2;
      cb_q[cmd_i.addr_a] <= {2'd0, res_y_q} + {8'd0, cur_h_q} + 16'd2;
      if (hp > ah_q) begin
        ah_q <= hp;
      end
    end
    if (cmd_i.out_load) begin
      m_tdata_o <= {5'd0, ah_q, aw_q, pos_b_q[24:11], pos_b_q[10:0], so_b_q[21:16]};
      m_tuser_o <= pos_b_q[25];
      m_tlast_o <= cmd_i.out_last;
    end
  end

endmodule

// ===== design/gap_ctrl.sv =====
// Packer sequencer: load count, rank pass, width, placement search and
// result delivery. Drives gap_dpath through gap_pkg::cmd_t.
`timescale 1ns / 1ps
module gap_ctrl #(
  parameter int unsigned MAX_RECTS = gap_pkg::GAP_MAX_RECTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           s_tlast_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  gap_pkg::stat_t stat_i,
  output gap_pkg::cmd_t  cmd_o
);
  import gap_pkg::*;

  typedef enum logic [4:0] {
    IDLE, RANK_I, RANK_KEY, RANK_JA, RANK_JB, RANK_WR,
    SQRT_GO, SQRT_WAIT, WIDTH_MUL, WIDTH_SET,
    PL_START, PL_CUR, PL_JA, PL_JB, PL_CHK, PL_WRITE,
    OUT_RD, OUT_LD, OUT_WAIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q, n_q, i_q, j_q;
  logic             side_q, m_tvalid_q;
  logic             room, i_more, j_more;

  assign room       = count_q < CNT_W'(MAX_RECTS);
  assign i_more     = (i_q + CNT_W'(1)) < n_q;
  assign j_more     = (state_q == RANK_JB) ? ((j_q + CNT_W'(1)) < n_q)
                                           : ((j_q + CNT_W'(1)) < i_q);
  assign s_tready_o = (state_q == IDLE);
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_addr = count_q[IDX_W-1:0];
    cmd_o.addr_a    = i_q[IDX_W-1:0];
    cmd_o.addr_b    = j_q[IDX_W-1:0];
    cmd_o.side      = side_q;
    cmd_o.res_op    = RES_HOLD;
    cmd_o.out_last  = !i_more;
    case (state_q)
      IDLE: begin
        cmd_o.load_we = s_tvalid_i && room;
        cmd_o.sum_clr = 1'b1;
      end
      RANK_KEY:  cmd_o.key_load   = 1'b1;
      RANK_JB:   cmd_o.rank_acc   = 1'b1;
      RANK_WR:   cmd_o.sort_we    = 1'b1;
      SQRT_GO:   cmd_o.sqrt_start = 1'b1;
      WIDTH_MUL: cmd_o.width_mul  = 1'b1;
      WIDTH_SET: cmd_o.width_set  = 1'b1;
      PL_CUR: begin
        cmd_o.cur_load = 1'b1;
        if (i_q == '0) begin
          cmd_o.res_op = RES_FIRST;
        end
      end
      PL_JB: cmd_o.cand_load = 1'b1;
      PL_CHK: begin
        if (stat_i.fit) begin
          cmd_o.res_op = RES_FIT;
        end else if (!j_more && side_q) begin
          cmd_o.res_op = RES_NONE;
        end
      end
      PL_WRITE: cmd_o.place_we = 1'b1;
      OUT_RD:   cmd_o.addr_b   = i_q[IDX_W-1:0];
      OUT_LD: begin
        cmd_o.addr_b   = i_q[IDX_W-1:0];
        cmd_o.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      count_q    <= '0;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      side_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        IDLE: begin
          if (s_tvalid_i) begin
            if (s_tlast_i) begin
              n_q     <= room ? count_q + CNT_W'(1) : count_q;
              count_q <= '0;
              i_q     <= '0;
              state_q <= RANK_I;
            end else if (room) begin
              count_q <= count_q + CNT_W'(1);
            end
          end
        end
        RANK_I: state_q <= RANK_KEY;
        RANK_KEY: begin
          j_q     <= '0;
          state_q <= RANK_JA;
        end
        RANK_JA: state_q <= RANK_JB;
        RANK_JB: begin
          if (j_more) begin
            j_q     <= j_q + CNT_W'(1);
            state_q <= RANK_JA;
          end else begin
            state_q <= RANK_WR;
          end
        end
        RANK_WR: begin
          if (i_more) begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= RANK_I;
          end else begin
            i_q     <= '0;
            state_q <= SQRT_GO;
          end
        end
        SQRT_GO: state_q <= SQRT_WAIT;
        SQRT_WAIT: begin
          if (stat_i.sqrt_done) begin
            state_q <= WIDTH_MUL;
          end
        end
        WIDTH_MUL: state_q <= WIDTH_SET;
        WIDTH_SET: state_q <= PL_START;
        PL_START:  state_q <= PL_CUR;
        PL_CUR: begin
          j_q    <= '0;
          side_q <= 1'b0;
          state_q <= (i_q == '0) ? PL_WRITE : PL_JA;
        end
        PL_JA: state_q <= PL_JB;
        PL_JB: state_q <= PL_CHK;
        PL_CHK: begin
          if (stat_i.fit) begin
            state_q <= PL_WRITE;
          end else if (j_more) begin
            j_q     <= j_q + CNT_W'(1);
            state_q <= PL_JA;
          end else if (!side_q) begin
            side_q  <= 1'b1;
            j_q     <= '0;
            state_q <= PL_JA;
          end else begin
            state_q <= PL_WRITE;
          end
        end
        PL_WRITE: begin
          if (i_more) begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= PL_START;
          end else begin
            i_q     <= '0;
            state_q <= OUT_RD;
          end
        end
        OUT_RD: state_q <= OUT_LD;
        OUT_LD: begin
          m_tvalid_q <= 1'b1;
          state_q    <= OUT_WAIT;
        end
        OUT_WAIT: begin
          if (m_tready_i) begin
            m_tvalid_q <= 1'b0;
            if (i_more) begin
              i_q     <= i_q + CNT_W'(1);
              state_q <= OUT_RD;
            end else begin
              state_q <= IDLE;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !m_tvalid_o) else $error("input open while a result is pending");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECTS)) else $error("rectangle count past limit");
  a_anchor_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PL_CHK) |-> (j_q < i_q)) else $error("anchor not an earlier rectangle");
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == OUT_WAIT && m_tready_i && !i_more) |=> s_tready_o)
    else $error("run did not return to load after final transfer");
`endif

endmodule

// ===== design/greedy_atlas_rectangle_packer.sv =====
// Top level of the greedy texture-atlas rectangle packer.
// Instantiates gap_ctrl and gap_dpath; uses gap_pkg.
`timescale 1ns / 1ps
// Rectangles stream in one transfer per cycle (width, height, tlast on the
// final one); up to MAX_RECTS are kept, extras are dropped. The final
// transfer starts packing and the input stays closed until every result
// has been taken. Packing runs three phases on one sequencer: a stable rank
// sort of (height, width) falling that compares one pair per pass through
// RANK_JA and RANK_JB, an 11-step square root for the atlas width, and
// greedy placement where each candidate spot (right of, then below, each
// earlier rectangle) passes through PL_JA, PL_JB and PL_CHK and is checked
// against all placed rectangles at once by a row of overlap cells. Results
// then leave in sorted order, each through OUT_RD, OUT_LD and OUT_WAIT and
// held there by stalls on m_tready_i; placed (tuser) is 0 with position 0
// when no spot fitted, and every result carries the final atlas size.
module greedy_atlas_rectangle_packer #(
  parameter int unsigned MAX_RECTS = gap_pkg::GAP_MAX_RECTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,  // [7:0] rect_width, [15:8] rect_height
  input  logic        s_tlast_i,  // last_rect
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [5:0] load_index, [16:6] pos_x, [30:17] pos_y, [42:31] atlas_width,
  // [58:43] atlas_height, [63:59] zero
  output logic [63:0] m_tdata_o,
  output logic        m_tuser_o,  // placed
  output logic        m_tlast_o   // last_result
);
  import gap_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gap_ctrl #(
    .MAX_RECTS (MAX_RECTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gap_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .rect_w_i  (s_tdata_i[7:0]),
    .rect_h_i  (s_tdata_i[15:8]),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o),
    .m_tlast_o (m_tlast_o)
  );

endmodule

// ===== test/tb_greedy_atlas_rectangle_packer.sv =====
// Testbench for greedy_atlas_rectangle_packer: streams rectangle sets, predicts the
// packed layout with a behavioral packer and checks every result transfer.
// Depends on gap_pkg and the packer RTL only.
`timescale 1ns / 1ps
module tb_greedy_atlas_rectangle_packer;
  import gap_pkg::*;

  typedef struct packed {
    logic [7:0] w;
    logic [7:0] h;
    logic       last;
  } rect_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [10:0] x;
    logic [13:0] y;
    logic        placed;
    logic [11:0] aw;
    logic [15:0] ah;
    logic        last;
  } place_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [15:0] s_tdata_i;
  logic        s_tlast_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [63:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;

  greedy_atlas_rectangle_packer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),  // [7:0] rect_width, [15:8] rect_height
    .s_tlast_i  (s_tlast_i),  // last_rect
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),  // idx, x, y, atlas width, atlas height
    .m_tuser_o  (m_tuser_o),  // placed
    .m_tlast_o  (m_tlast_o)   // last_result
  );

  rect_t  rect_queue[$];
  place_t layout_queue[$];

  // predictor state: the set being loaded
  logic [7:0] set_w[64];
  logic [7:0] set_h[64];
  int         set_count;

  int errors;
  int results_seen;
  int sets_packed;
  int unplaced_seen;
  int idle_send_pct;
  int idle_recv_pct;
  int hold_cycles;
  bit hold_want;
  bit hold_used;
  bit stim_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pow2_up(int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  function automatic int unsigned isqrt(int unsigned a);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= a) r++;
    return r;
  endfunction

  // sort, size the atlas, place greedily and queue one layout entry per rectangle
  task automatic pack_set();
    int unsigned sw[64], sh[64], so[64], px[64], py[64];
    bit          ok[64];
    int unsigned n, i, j, k, area, widest, r, aw, ah, bx, by, bw, bh, tw, th, t_o;
    int          side;
    bit          done, fits;
    place_t      e;
    n = set_count;
    for (i = 0; i < n; i++) begin
      sw[i] = set_w[i];
      sh[i] = set_h[i];
      so[i] = i;
    end
    // stable insertion sort, height then width falling
    for (i = 1; i < n; i++) begin
      tw = sw[i]; th = sh[i]; t_o = so[i];
      j = i;
      while (j > 0 && (sh[j-1] < th || (sh[j-1] == th && sw[j-1] < tw))) begin
        sw[j] = sw[j-1]; sh[j] = sh[j-1]; so[j] = so[j-1];
        j--;
      end
      sw[j] = tw; sh[j] = th; so[j] = t_o;
    end
    area = 0;
    widest = 0;
    for (i = 0; i < n; i++) begin
      area += sw[i] * sh[i];
      if (widest < sw[i] + 2) widest = sw[i] + 2;
    end
    r = isqrt(area);
    if (area > r * r + r) r++;
    aw = (r > widest) ? r : widest;
    if (aw > 2048) aw = 2048;
    aw = pow2_up(aw);
    ah = 0;
    for (i = 0; i < n; i++) begin
      bw = sw[i] + 2;
      bh = sh[i] + 2;
      ok[i] = 0; px[i] = 0; py[i] = 0;
      done = (i == 0);
      if (done) begin
        px[i] = 1; py[i] = 1;
      end
      for (side = 0; side < 2 && !done; side++) begin
        for (j = 0; j < i && !done; j++) begin
          if (!ok[j]) continue;
          if (side == 0) begin
            bx = px[j] + sw[j] + 1; by = py[j];
          end else begin
            bx = px[j]; by = py[j] + sh[j] + 1;
          end
          fits = (bx + bw <= aw);
          for (k = 0; k < i && fits; k++) begin
            if (!ok[k]) continue;
            if (!((bx + 1 + bw <= px[k]) || (by + 1 + bh <= py[k]) ||
                  (bx + 1 >= px[k] + sw[k] + 2) || (by + 1 >= py[k] + sh[k] + 2)))
              fits = 0;
          end
          if (fits) begin
            px[i] = (bx + (side == 0)) & 'h7FF;
            py[i] = (by + (side == 1)) & 'h3FFF;
            done = 1;
          end
        end
      end
      if (done) begin
        ok[i] = 1;
        if (pow2_up(py[i] + sh[i]) > ah) ah = pow2_up(py[i] + sh[i]);
      end
    end
    for (i = 0; i < n; i++) begin
      e.idx = 6'(so[i]);
      e.x = 11'(px[i]);
      e.y = 14'(py[i]);
      e.placed = ok[i];
      e.aw = 12'(aw);
      e.ah = 16'(ah);
      e.last = (i + 1 == n);
      layout_queue.push_back(e);
    end
    set_count = 0;
    sets_packed++;
  endtask

  task automatic load_rect(rect_t rc);
    if (set_count < GAP_MAX_RECTS) begin
      set_w[set_count] = rc.w;
      set_h[set_count] = rc.h;
      set_count++;
    end
    if (rc.last) pack_set();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic rect_t mk(int w, int h, bit last);
    rect_t rc;
    rc.w = 8'(w);
    rc.h = 8'(h);
    rc.last = last;
    return rc;
  endfunction

  // random set: mostly small rectangles, occasionally a wide or tall one
  task automatic add_random_set(int n);
    int w, h, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = $urandom_range(0, 254); h = $urandom_range(0, 254);
      end else if (sel == 1) begin
        w = $urandom_range(200, 254); h = $urandom_range(0, 8);
      end else begin
        w = $urandom_range(0, 40); h = $urandom_range(0, 40);
      end
      rect_queue.push_back(mk(w, h, i == n - 1));
    end
  endtask

  // driver: one transfer offered at a time, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
      s_tlast_i  <= 1'b0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        load_rect(rect_queue.pop_front());
      end
      if ((!s_tvalid_i || s_tready_o) && stim_done == 0) begin
        if (rect_queue.size() > 0 && $urandom_range(0, 99) >= idle_send_pct) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= {rect_queue[0].h, rect_queue[0].w};
          s_tlast_i  <= rect_queue[0].last;
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // tready stalls: random, plus one long hold-off counted here once results show up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i  <= 1'b0;
      hold_cycles <= 0;
      hold_used   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready_i  <= 1'b0;
    end else if (hold_want && !hold_used && m_tvalid_o) begin
      hold_used   <= 1'b1;
      hold_cycles <= 400;
      m_tready_i  <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(0, 99) >= idle_recv_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    place_t e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (layout_queue.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        e = layout_queue.pop_front();
        if (m_tdata_o[5:0] !== e.idx) report_mismatch("load_index", m_tdata_o[5:0], e.idx);
        if (m_tdata_o[16:6] !== e.x) report_mismatch("pos_x", m_tdata_o[16:6], e.x);
        if (m_tdata_o[30:17] !== e.y) report_mismatch("pos_y", m_tdata_o[30:17], e.y);
        if (m_tuser_o !== e.placed) report_mismatch("placed", m_tuser_o, e.placed);
        if (m_tdata_o[42:31] !== e.aw) report_mismatch("atlas_width", m_tdata_o[42:31], e.aw);
        if (m_tdata_o[58:43] !== e.ah) report_mismatch("atlas_height", m_tdata_o[58:43], e.ah);
        if (m_tdata_o[63:59] !== 5'd0) report_mismatch("pad bits", m_tdata_o[63:59], 0);
        if (m_tlast_o !== e.last) report_mismatch("last_result", m_tlast_o, e.last);
        if (!e.placed) unplaced_seen++;
      end
      results_seen++;
    end
  end

  task automatic drain();
    while (rect_queue.size() > 0 || layout_queue.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int total;
    int n;
    rst_ni = 1'b0;
    errors = 0; results_seen = 0; sets_packed = 0; unplaced_seen = 0;
    set_count = 0; hold_want = 0; stim_done = 0;
    idle_send_pct = 36;
    idle_recv_pct = 81;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single rectangle, zero sizes, extremes and ties
    rect_queue.push_back(mk(0, 0, 1));
    rect_queue.push_back(mk(254, 254, 1));
    rect_queue.push_back(mk(5, 5, 0));
    rect_queue.push_back(mk(5, 5, 0));
    rect_queue.push_back(mk(7, 5, 0));
    rect_queue.push_back(mk(0, 9, 0));
    rect_queue.push_back(mk(9, 0, 1));
    rect_queue.push_back(mk(254, 1, 0));
    rect_queue.push_back(mk(1, 254, 0));
    rect_queue.push_back(mk(170, 85, 0));
    rect_queue.push_back(mk(85, 170, 1));
    // narrow atlas: three small squares and one wider rectangle
    rect_queue.push_back(mk(2, 2, 0));
    rect_queue.push_back(mk(2, 2, 0));
    rect_queue.push_back(mk(2, 2, 0));
    rect_queue.push_back(mk(3, 1, 1));
    drain();

    // full store with dropped extras; results get held off while the next set waits
    hold_want = 1;
    for (int i = 0; i < 67; i++)
      rect_queue.push_back(mk($urandom_range(0, 254), $urandom_range(0, 254), i == 66));
    add_random_set(5);
    drain();

    total = 0;
    while (total < 366) begin
      if (total >= 244) begin
        idle_send_pct = 0; idle_recv_pct = 0;
      end else if (total >= 122) begin
        idle_send_pct = 81; idle_recv_pct = 36;
      end
      n = $urandom_range(1, 12);
      add_random_set(n);
      total += n;
      if (rect_queue.size() > 20) drain();
    end
    drain();
    stim_done = 1;
    repeat (200) @(posedge clk_i);
    $display("covered %0d packed sets, %0d results, %0d unplaced rectangles",
             sets_packed, results_seen, unplaced_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
